### design/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// shared types and constants for the grid least-path-sum block
// ----------------------------------------------------------------------------
package gmps_pkg;

	localparam int DIM_BITS  = 6;
	localparam int OUT_BITS  = 26;
	localparam int DIST_BITS = 32;

	localparam logic [DIM_BITS-1:0] REG_ROWS = 6'd0;
	localparam logic [DIM_BITS-1:0] REG_COLS = 6'd1;

	localparam logic [DIST_BITS-1:0] DIST_INF = '1;

	typedef logic [DIM_BITS-1:0] dim_t;

endpackage

### design/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram
// single-port synchronous ram, one write and one read per cycle at one address, registered read
// ----------------------------------------------------------------------------
module gmps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### design/grid_min_path_sum_top.sv
// ----------------------------------------------------------------------------
// grid_min_path_sum_top
// loads a cost grid and finds the least 4-neighbor path sum with a heap search
// ----------------------------------------------------------------------------
// channel   | handshake                   | payload
// cfg       | cfg_valid / cfg_ready       | cfg_index, cfg_data
// in        | in_valid / in_ready         | cell_cost
// out       | out_valid / out_ready       | path_cost
//
// loading stores one cell per accepted input; the last cell starts the search.
// search: an init sweep over every cell, a seed of cell 0, then per pop a read
// of the heap root and of the last entry, a sift-down level by level (the right
// child read only if a left child exists), the stale check, and per neighbor a skip or
// a relax with a sift-up push; a final read of the last cell's distance finishes.
// no input is taken while a search runs or while its result is held.
// reset clears control state only; the rams are written before they are read.
module grid_min_path_sum_top #(
	parameter int MAX_ROWS   = 32,
	parameter int MAX_COLS   = 32,
	parameter int COST_BITS  = 16,
	parameter int HEAP_DEPTH = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [0:0]              cfg_index,
	input  gmps_pkg::dim_t          cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COST_BITS-1:0]    cell_cost,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [gmps_pkg::OUT_BITS-1:0] path_cost
);
	import gmps_pkg::*;

	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int CA      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW      = CA + 1;
	localparam int HA      = $clog2(HEAP_DEPTH);
	localparam int HW      = HA + 1;
	localparam int RB      = $clog2(MAX_ROWS + 1);
	localparam int CB      = $clog2(MAX_COLS + 1);
	localparam int EW      = DIST_BITS + CW + CB;

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_INIT  = 5'd1;
	localparam logic [4:0] S_SEED  = 5'd2;
	localparam logic [4:0] S_SEED2 = 5'd3;
	localparam logic [4:0] S_POP   = 5'd4;
	localparam logic [4:0] S_POP1  = 5'd5;
	localparam logic [4:0] S_POPL  = 5'd6;
	localparam logic [4:0] S_POPL1 = 5'd7;
	localparam logic [4:0] S_SDL   = 5'd8;
	localparam logic [4:0] S_SDL1  = 5'd9;
	localparam logic [4:0] S_SDR   = 5'd10;
	localparam logic [4:0] S_SDR1  = 5'd11;
	localparam logic [4:0] S_SDW   = 5'd12;
	localparam logic [4:0] S_CHK   = 5'd13;
	localparam logic [4:0] S_CHK1  = 5'd14;
	localparam logic [4:0] S_NB    = 5'd15;
	localparam logic [4:0] S_NBC   = 5'd16;
	localparam logic [4:0] S_NBD   = 5'd17;
	localparam logic [4:0] S_NBR   = 5'd18;
	localparam logic [4:0] S_PUSH  = 5'd19;
	localparam logic [4:0] S_PUSH1 = 5'd20;
	localparam logic [4:0] S_FIN   = 5'd21;
	localparam logic [4:0] S_FIN1  = 5'd22;
	localparam logic [4:0] S_OUT   = 5'd23;

	logic [4:0] state_q;
	dim_t rows_reg_q, cols_reg_q;
	logic [CW-1:0] load_q;

	logic [RB-1:0] rows_c;
	logic [CB-1:0] cols_c;
	logic [CW-1:0] total_c;

	// dimensions latched for the search
	logic [CW-1:0] total_q;
	logic [CB-1:0] cols_q;

	logic [CW-1:0] idx_q;      // sweep index
	logic [CB-1:0] col_q;      // column of current cell
	logic [HW-1:0] hcnt_q;
	logic [HW-1:0] hi_q;       // heap position
	logic [EW-1:0] ent_q;      // entry being placed
	logic [EW-1:0] best_q;
	logic [HW-1:0] bidx_q;
	logic [DIST_BITS-1:0] pd_q;  // popped distance
	logic [CW-1:0] pv_q;         // popped cell
	logic [1:0] nbi_q;
	logic [CW-1:0] nb_q;
	logic [DIST_BITS:0] nd_q;
	logic [DIST_BITS-1:0] d_wdata_cmp_q; // dist of neighbor as read
	logic [OUT_BITS-1:0] res_q;

	// ram ports
	logic c_we, d_we, h_we;
	logic [CA-1:0] c_addr, d_addr;
	logic [HA-1:0] h_addr;
	logic [COST_BITS-1:0] c_wdata, c_rdata;
	logic [DIST_BITS-1:0] d_wdata, d_rdata;
	logic [EW-1:0] h_wdata, h_rdata;

	gmps_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));
	gmps_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist (
		.clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));
	gmps_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

	always_comb begin
		if (rows_reg_q == '0) begin
			rows_c = RB'(1);
		end else if ({26'd0, rows_reg_q} > 32'(MAX_ROWS)) begin
			rows_c = RB'(MAX_ROWS);
		end else begin
			rows_c = RB'(rows_reg_q);
		end
		if (cols_reg_q == '0) begin
			cols_c = CB'(1);
		end else if ({26'd0, cols_reg_q} > 32'(MAX_COLS)) begin
			cols_c = CB'(MAX_COLS);
		end else begin
			cols_c = CB'(cols_reg_q);
		end
	end
	assign total_c = CW'(rows_c * cols_c);

	// heap entry helpers: distance high, then cell, then its column, so a plain
	// compare orders them
	function automatic logic [DIST_BITS-1:0] e_dist(input logic [EW-1:0] e);
		return e[EW-1:CW+CB];
	endfunction
	function automatic logic [CW-1:0] e_cell(input logic [EW-1:0] e);
		return e[CW+CB-1:CB];
	endfunction
	function automatic logic [CB-1:0] e_col(input logic [EW-1:0] e);
		return e[CB-1:0];
	endfunction

	logic [HW-1:0] par_c, lch_c, rch_c;
	assign par_c = (hi_q - HW'(1)) >> 1;
	assign lch_c = {hi_q[HW-2:0], 1'b1};
	assign rch_c = lch_c + HW'(1);

	// neighbor selection
	logic nb_ok;
	logic [CW-1:0] nb_c;
	logic [CB-1:0] nb_col_c;
	always_comb begin
		nb_ok    = 1'b0;
		nb_c     = pv_q;
		nb_col_c = col_q;
		unique case (nbi_q)
			2'd0: begin
				nb_ok    = (CB'(col_q + CB'(1)) < cols_q) && (col_q + CB'(1) != '0);
				nb_c     = pv_q + CW'(1);
				nb_col_c = col_q + CB'(1);
			end
			2'd1: begin
				nb_ok    = (col_q != '0);
				nb_c     = pv_q - CW'(1);
				nb_col_c = col_q - CB'(1);
			end
			2'd2: begin
				nb_ok = ({1'b0, pv_q} + {1'b0, CW'(cols_q)}) < {1'b0, total_q};
				nb_c  = pv_q + CW'(cols_q);
			end
			default: begin
				nb_ok = (pv_q >= CW'(cols_q));
				nb_c  = pv_q - CW'(cols_q);
			end
		endcase
	end

	assign cfg_ready = (state_q == S_LOAD);
	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign path_cost = res_q;

	logic [CW-1:0] load_next;
	assign load_next = load_q + CW'(1);

	always_comb begin
		c_we = 1'b0; c_addr = load_q[CA-1:0]; c_wdata = cell_cost;
		d_we = 1'b0; d_addr = idx_q[CA-1:0]; d_wdata = DIST_INF;
		h_we = 1'b0; h_addr = hi_q[HA-1:0]; h_wdata = ent_q;
		unique case (state_q)
			S_LOAD: begin
				c_we = in_valid && ({1'b0, load_q} < (CW+1)'(CELLS));
			end
			S_INIT: begin
				d_we = 1'b1;
			end
			S_SEED: begin
				c_addr = '0;
			end
			S_SEED2: begin
				d_we = 1'b1; d_addr = '0; d_wdata = DIST_BITS'(c_rdata);
				h_we = 1'b1; h_addr = '0;
				h_wdata = {DIST_BITS'(c_rdata), CW'(0), CB'(0)};
			end
			S_POP: begin
				h_addr = '0;
			end
			S_POPL: begin
				h_addr = hcnt_q[HA-1:0];
			end
			S_SDL: begin
				h_addr = lch_c[HA-1:0];
			end
			S_SDR: begin
				h_addr = rch_c[HA-1:0];
			end
			S_SDW: begin
				h_we = 1'b1;
				h_wdata = (bidx_q == hi_q) ? ent_q : best_q;
			end
			S_CHK: begin
				d_addr = pv_q[CA-1:0];
			end
			S_NBC: begin
				c_addr = nb_q[CA-1:0]; d_addr = nb_q[CA-1:0];
			end
			S_NBR: begin
				d_addr = nb_q[CA-1:0];
				d_we = (nd_q < {1'b0, d_wdata_cmp_q});
				d_wdata = nd_q[DIST_BITS-1:0];
			end
			S_PUSH: begin
				h_addr = par_c[HA-1:0];
			end
			S_PUSH1: begin
				h_we = 1'b1;
				h_wdata = (hi_q != '0 && ent_q < h_rdata) ? h_rdata : ent_q;
			end
			S_FIN: begin
				d_addr = CA'(total_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			rows_reg_q <= dim_t'(1);
			cols_reg_q <= dim_t'(1);
			load_q     <= '0;
			hcnt_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (cfg_valid) begin
						if (cfg_index == REG_ROWS[0:0]) rows_reg_q <= cfg_data;
						else cols_reg_q <= cfg_data;
					end
					if (in_valid) begin
						if (load_next >= total_c) begin
							load_q  <= '0;
							total_q <= total_c;
							cols_q  <= cols_c;
							idx_q   <= '0;
							state_q <= S_INIT;
						end else begin
							load_q <= load_next;
						end
					end
				end
				S_INIT: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(1) == total_q) state_q <= S_SEED;
				end
				S_SEED: state_q <= S_SEED2;
				S_SEED2: begin
					hcnt_q  <= HW'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					if (hcnt_q == '0) state_q <= S_FIN;
					else state_q <= S_POP1;
				end
				S_POP1: begin
					pd_q   <= e_dist(h_rdata);
					pv_q   <= e_cell(h_rdata);
					col_q  <= e_col(h_rdata);
					hcnt_q <= hcnt_q - HW'(1);
					if (hcnt_q == HW'(1)) state_q <= S_CHK;
					else state_q <= S_POPL;
				end
				S_POPL: state_q <= S_POPL1;
				S_POPL1: begin
					ent_q   <= h_rdata;
					best_q  <= h_rdata;
					hi_q    <= '0;
					bidx_q  <= '0;
					state_q <= S_SDL;
				end
				S_SDL: state_q <= S_SDL1;
				S_SDL1: begin
					if (lch_c < hcnt_q && h_rdata < ent_q) begin
						best_q <= h_rdata;
						bidx_q <= lch_c;
					end else begin
						best_q <= ent_q;
						bidx_q <= hi_q;
					end
					if (lch_c < hcnt_q) state_q <= S_SDR;
					else state_q <= S_SDW;
				end
				S_SDR: state_q <= S_SDR1;
				S_SDR1: begin
					if (rch_c < hcnt_q && h_rdata < best_q) begin
						best_q <= h_rdata;
						bidx_q <= rch_c;
					end
					state_q <= S_SDW;
				end
				S_SDW: begin
					if (bidx_q == hi_q) begin
						state_q <= S_CHK;
					end else begin
						hi_q    <= bidx_q;
						state_q <= S_SDL;
					end
				end
				S_CHK: state_q <= S_CHK1;
				S_CHK1: begin
					// skip out-of-range or stale entries
					if (pv_q >= total_q || pd_q > d_rdata) begin
						state_q <= S_POP;
					end else begin
						nbi_q   <= 2'd0;
						state_q <= S_NB;
					end
				end
				S_NB: begin
					nb_q <= nb_c;
					if (nb_ok) state_q <= S_NBC;
					else if (nbi_q == 2'd3) state_q <= S_POP;
					else nbi_q <= nbi_q + 2'd1;
				end
				S_NBC: state_q <= S_NBD;
				S_NBD: begin
					nd_q <= {1'b0, pd_q} + (DIST_BITS+1)'(c_rdata);
					d_wdata_cmp_q <= d_rdata;
					state_q <= S_NBR;
				end
				S_NBR: begin
					// a push into a full heap is dropped, the distance still updates
					if (d_we && ({1'b0, hcnt_q} < (HW+1)'(HEAP_DEPTH))) begin
						ent_q   <= {nd_q[DIST_BITS-1:0], nb_q, nb_col_c};
						hi_q    <= hcnt_q;
						hcnt_q  <= hcnt_q + HW'(1);
						state_q <= S_PUSH;
					end else if (nbi_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						nbi_q   <= nbi_q + 2'd1;
						state_q <= S_NB;
					end
				end
				S_PUSH: state_q <= S_PUSH1;
				S_PUSH1: begin
					if (hi_q != '0 && ent_q < h_rdata) begin
						hi_q    <= par_c;
						state_q <= S_PUSH;
					end else begin
						if (nbi_q == 2'd3) state_q <= S_POP;
						else begin
							nbi_q   <= nbi_q + 2'd1;
							state_q <= S_NB;
						end
					end
				end
				S_FIN: state_q <= S_FIN1;
				S_FIN1: begin
					res_q   <= d_rdata[OUT_BITS-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// assertions
	a_hcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, hcnt_q} <= (HW+1)'(HEAP_DEPTH))
		else $error("heap count beyond depth");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(path_cost))
		else $error("result changed while held");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> {1'b0, load_q} < (CW+1)'(CELLS))
		else $error("load index beyond cost store");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_LOAD |-> !in_ready && !cfg_ready)
		else $error("input taken during search");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// grid least-path-sum testbench
// loads cost grids of many shapes and checks each least path sum against a
// local dijkstra predictor, with random input gaps and output stalls
// ----------------------------------------------------------------------------
module testbench;

	import gmps_pkg::*;

	localparam int MAX_DIM    = 32;
	localparam int CELL_SLOTS = MAX_DIM * MAX_DIM;
	localparam int CYCLE_CAP  = 20000000;
	localparam int SETTLE     = 64;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [0:0]          cfg_index;
	dim_t                cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [15:0]         cell_cost;
	logic                out_valid;
	logic                out_ready;
	logic [OUT_BITS-1:0] path_cost;

	grid_min_path_sum_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cell_cost (cell_cost),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.path_cost (path_cost)
	);

	// predictor state
	dim_t               grid_rows_reg;
	dim_t               grid_cols_reg;
	logic [15:0]        cost_copy [CELL_SLOTS];
	int unsigned        cells_loaded;
	logic [OUT_BITS-1:0] path_sum_q [$];

	int unsigned errors;
	int unsigned cycles;
	int unsigned cells_sent;
	int unsigned sums_checked;
	int unsigned burst_left;
	int unsigned gap_max;
	int unsigned hold_cycles;
	bit          rx_choppy;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: long hold-offs on request, otherwise steady or choppy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (rx_choppy) begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (path_sum_q.size() == 0) begin
				$error("path_cost: no result expected, got %0d", path_cost);
				errors++;
			end else begin
				logic [OUT_BITS-1:0] want;
				want = path_sum_q.pop_front();
				if (path_cost !== want) begin
					$error("path_cost: expected %0d, actual %0d", want, path_cost);
					errors++;
				end
				sums_checked++;
			end
		end
	end

	function automatic int unsigned eff_dim(dim_t raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return 32'(raw);
	endfunction

	// plain O(n^2) dijkstra over the stored costs
	function automatic logic [OUT_BITS-1:0] least_path_sum(int unsigned rows,
			int unsigned cols);
		longint unsigned dist_v [CELL_SLOTS];
		bit              done [CELL_SLOTS];
		int unsigned     total;
		int unsigned     v;
		int              best;
		int              nb [4];
		total = rows * cols;
		for (int i = 0; i < total; i++) begin
			dist_v[i] = 64'hFFFF_FFFF;
			done[i] = 1'b0;
		end
		dist_v[0] = cost_copy[0];
		for (int k = 0; k < total; k++) begin
			best = -1;
			for (int i = 0; i < total; i++)
				if (!done[i] && (best < 0 || dist_v[i] < dist_v[best]))
					best = i;
			v = 32'(best);
			done[v] = 1'b1;
			nb[0] = (v % cols + 1 < cols) ? int'(v + 1) : -1;
			nb[1] = (v % cols > 0) ? int'(v - 1) : -1;
			nb[2] = (v + cols < total) ? int'(v + cols) : -1;
			nb[3] = (v >= cols) ? int'(v - cols) : -1;
			foreach (nb[j])
				if (nb[j] >= 0 && dist_v[v] + cost_copy[nb[j]] < dist_v[nb[j]])
					dist_v[nb[j]] = dist_v[v] + cost_copy[nb[j]];
		end
		return dist_v[total - 1][OUT_BITS-1:0];
	endfunction

	function automatic void predict_cell(logic [15:0] c);
		int unsigned rows;
		int unsigned cols;
		rows = eff_dim(grid_rows_reg);
		cols = eff_dim(grid_cols_reg);
		if (cells_loaded < CELL_SLOTS)
			cost_copy[cells_loaded] = c;
		cells_loaded++;
		if (cells_loaded >= rows * cols) begin
			cells_loaded = 0;
			path_sum_q = {path_sum_q, least_path_sum(rows, cols)};
		end
	endfunction

	task automatic send_cell(input logic [15:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, gap_max);
			if (gap > 0 || !in_valid) begin
				in_valid <= 1'b0;
				repeat (gap + 1) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		cell_cost <= c;
		burst_left--;
		do
			@(posedge clk);
		while (!in_ready);
		cells_sent++;
		predict_cell(c);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (path_sum_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input dim_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS[0:0])
			grid_rows_reg = val;
		else
			grid_cols_reg = val;
	endtask

	task automatic set_shape(input dim_t rows, input dim_t cols);
		wait_drained();
		write_reg(REG_ROWS[0:0], rows);
		write_reg(REG_COLS[0:0], cols);
	endtask

	function automatic logic [15:0] rand_cost();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 9));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_grid(input int unsigned n);
		repeat (n) send_cell(rand_cost());
	endtask

	task automatic test_directed();
		gap_max = 0;
		// reset shape is one cell
		send_cell(16'h0000);
		send_cell(16'hFFFF);
		// zero dimensions behave as one
		set_shape(6'd0, 6'd0);
		send_cell(16'h1234);
		set_shape(6'd2, 6'd2);
		repeat (4) send_cell(16'hFFFF);
		// oversized column count saturates to a single 32-wide row
		set_shape(6'd1, 6'd63);
		for (int i = 0; i < 32; i++)
			send_cell(i[0] ? 16'hFFFF : 16'h0000);
		// 3x3 with a cheap detour around a costly center
		set_shape(6'd3, 6'd3);
		send_cell(16'd1); send_cell(16'd9); send_cell(16'd1);
		send_cell(16'd1); send_cell(16'hFFFF); send_cell(16'd1);
		send_cell(16'd1); send_cell(16'd9); send_cell(16'd1);
	endtask

	// shrink the shape mid-load: the next cell finishes the smaller grid
	task automatic test_shape_change_mid_load();
		set_shape(6'd3, 6'd3);
		repeat (5) send_cell(rand_cost());
		set_shape(6'd1, 6'd4);
		send_cell(rand_cost());
		set_shape(6'd63, 6'd1);
		send_grid(32);
	endtask

	task automatic test_random_grids();
		dim_t r;
		dim_t c;
		while (cells_sent < 950) begin
			rx_choppy = $urandom_range(0, 1);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			case ($urandom_range(0, 9))
				0: begin r = 6'($urandom_range(0, 63)); c = 6'd1; end
				1: begin r = 6'd1; c = 6'($urandom_range(0, 63)); end
				2: begin
					r = 6'($urandom_range(6, 10));
					c = 6'($urandom_range(6, 10));
				end
				default: begin
					r = 6'($urandom_range(1, 6));
					c = 6'($urandom_range(1, 6));
				end
			endcase
			set_shape(r, c);
			send_grid(eff_dim(r) * eff_dim(c) * $urandom_range(1, 4));
		end
	endtask

	task automatic test_full_grid();
		rx_choppy = 1'b1;
		gap_max = 2;
		set_shape(6'd32, 6'd32);
		send_grid(CELL_SLOTS);
	endtask

	// receiver holds off while one-cell grids keep coming in
	task automatic test_backpressure();
		set_shape(6'd1, 6'd1);
		rx_choppy = 1'b0;
		gap_max = 0;
		hold_cycles = 1500;
		repeat (20) send_cell(rand_cost());
		wait_drained();
		repeat (10) send_cell(rand_cost());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cell_cost = '0;
		errors = 0;
		cycles = 0;
		cells_sent = 0;
		sums_checked = 0;
		burst_left = 0;
		gap_max = 0;
		hold_cycles = 0;
		rx_choppy = 1'b0;
		grid_rows_reg = 6'd1;
		grid_cols_reg = 6'd1;
		cells_loaded = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_shape_change_mid_load();
		test_random_grids();
		test_backpressure();
		test_full_grid();
		wait_drained();

		$display("sent %0d cells, checked %0d path sums", cells_sent, sums_checked);
		$display("shapes 1x1 to 32x32 incl. zero and oversized dims, mid-load resize");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
design/gmps_pkg.sv
design/gmps_ram.sv
design/grid_min_path_sum_top.sv
test/testbench.sv
